// ----- design/blaw_pkg.sv -----
// Shared types and constants for the block-linear area pixel writer.
// No dependencies; imported by every module of the block.
package blaw_pkg;

   localparam int COORD_W   = 9;
   localparam int ADDR_W    = 18;
   localparam int PIXEL_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 9;

   typedef logic [COORD_W-1:0]   coord_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [PIXEL_W-1:0]   pixel_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [CSR_DAT_W-1:0] csr_dat_type;

   localparam csr_idx_type CSR_AREA_LEFT     = 3'd0;
   localparam csr_idx_type CSR_AREA_RIGHT    = 3'd1;
   localparam csr_idx_type CSR_AREA_TOP      = 3'd2;
   localparam csr_idx_type CSR_AREA_BOTTOM   = 3'd3;
   localparam csr_idx_type CSR_RENDER_ENABLE = 3'd4;

   localparam coord_type AREA_LEFT_RST   = 9'd0;
   localparam coord_type AREA_RIGHT_RST  = 9'd511;
   localparam coord_type AREA_TOP_RST    = 9'd0;
   localparam coord_type AREA_BOTTOM_RST = 9'd511;

   // Rectangle bounds, all inclusive.
   typedef struct packed {
      coord_type left;
      coord_type right;
      coord_type top;
      coord_type bottom;
   } area_type;

   // Position of the current pixel and whether it closes the rectangle.
   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } pos_type;

endpackage

// ----- design/blaw_position.sv -----
// Column and row counters that walk the configured rectangle in raster order.
// Depends on blaw_pkg.
module blaw_position (
   input  logic              clock,
   input  logic              reset,
   input  blaw_pkg::area_type area,
   input  logic              rewind,
   input  logic              advance,
   output blaw_pkg::pos_type pos
);
   import blaw_pkg::*;

   coord_type column_ff, column_in;
   coord_type row_ff, row_in;
   logic      row_end;
   logic      last;

   // Comparisons use >= so that a start beyond its end still terminates.
   assign row_end = (column_ff >= area.right);
   assign last    = row_end && (row_ff >= area.bottom);

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (rewind) begin
         column_in = area.left;
         row_in    = area.top;
      end else if (advance) begin
         if (last) begin
            column_in = area.left;
            row_in    = area.top;
         end else if (row_end) begin
            column_in = area.left;
            row_in    = row_ff + coord_type'(1);
         end else begin
            column_in = column_ff + coord_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= AREA_LEFT_RST;
         row_ff    <= AREA_TOP_RST;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   assign pos.x    = column_ff;
   assign pos.y    = row_ff;
   assign pos.last = last;

endmodule

// ----- design/blaw_swizzle.sv -----
// Block-linear word address of a pixel: 16x16-word GOBs stacked eight high.
// Depends on blaw_pkg.
module blaw_swizzle #(
   parameter int BUFFER_WIDTH = 512
) (
   input  blaw_pkg::coord_type x,
   input  blaw_pkg::coord_type y,
   output blaw_pkg::addr_type  word_address
);
   import blaw_pkg::*;

   localparam int GOB_W         = ADDR_W - 8;
   localparam int GobsPerRow    = (BUFFER_WIDTH / 16) * 8;
   localparam int GobsPerRowMod = GobsPerRow % (1 << GOB_W);
   localparam logic [GOB_W-1:0] GOB_ROW_STEP = GOB_W'(GobsPerRowMod);

   logic [GOB_W-1:0] gob_local;
   logic [GOB_W-1:0] gob_band;
   logic [GOB_W-1:0] gob;
   logic [7:0]       offset;

   // The column GOB times eight and the GOB within the block occupy
   // disjoint bits, so they are simply concatenated.
   assign gob_local = GOB_W'({x[8:4], y[6:4]});
   assign gob_band  = GOB_W'({{(GOB_W-2){1'b0}}, y[8:7]} * GOB_ROW_STEP);
   assign gob       = gob_local + gob_band;

   assign offset = {y[3], x[3], y[2:1], x[2], y[0], x[1:0]};

   assign word_address = {gob, offset};

endmodule

// ----- design/block_linear_area_pixel_writer.sv -----
// Block-linear area pixel writer: raster pixels in, block-linear addresses out.
// Pipeline: a pixel is registered in the input stage at its transfer and moves on to the
// result register once that is free; its result transfer is made from there.
// Throughput: one pixel per cycle while rsp_ready stays high, set by both registers.
// Reset: synchronous; area resets to the full 512x512 field, rendering enabled,
// counters at the top-left corner, both pipeline stages empty.
// Depends on blaw_pkg, blaw_position and blaw_swizzle.
module block_linear_area_pixel_writer #(
   parameter int BUFFER_WIDTH = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  blaw_pkg::csr_idx_type csr_index,
   input  blaw_pkg::csr_dat_type csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  blaw_pkg::pixel_type   req_pixel_color,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output blaw_pkg::addr_type    rsp_word_address,
   output blaw_pkg::pixel_type   rsp_pixel_out,
   output logic                  rsp_last_of_area
);
   import blaw_pkg::*;

   area_type  area_ff, area_in;
   logic      render_enable_ff, render_enable_in;
   logic      area_write;
   logic      req_accept;
   logic      advance;
   pos_type   cur_pos;

   logic      s1_valid_ff, s1_valid_in;
   pixel_type s1_pixel_ff;
   pos_type   s1_pos_ff;
   logic      s1_move;

   logic      rsp_valid_ff, rsp_valid_in;
   addr_type  rsp_addr_ff;
   pixel_type rsp_pixel_ff;
   logic      rsp_last_ff;
   addr_type  s1_addr;

   // Configuration registers.
   always_comb begin
      area_in          = area_ff;
      render_enable_in = render_enable_ff;
      area_write       = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_AREA_LEFT: begin
               area_in.left = csr_write_data;
               area_write   = 1'b1;
            end
            CSR_AREA_RIGHT: begin
               area_in.right = csr_write_data;
               area_write    = 1'b1;
            end
            CSR_AREA_TOP: begin
               area_in.top = csr_write_data;
               area_write  = 1'b1;
            end
            CSR_AREA_BOTTOM: begin
               area_in.bottom = csr_write_data;
               area_write     = 1'b1;
            end
            CSR_RENDER_ENABLE: begin
               render_enable_in = csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff.left     <= AREA_LEFT_RST;
         area_ff.right    <= AREA_RIGHT_RST;
         area_ff.top      <= AREA_TOP_RST;
         area_ff.bottom   <= AREA_BOTTOM_RST;
         render_enable_ff <= 1'b1;
      end else begin
         area_ff          <= area_in;
         render_enable_ff <= render_enable_in;
      end
   end

   assign req_accept = req_valid && req_ready;
   // A dropped pixel is still taken from the source but leaves the counters alone.
   assign advance    = req_accept && render_enable_ff;

   // The counters see the next area value, so a rewind lands on the bounds being written
   // at the same edge as the area registers take them.
   blaw_position u_position (
      .clock   (clock),
      .reset   (reset),
      .area    (area_in),
      .rewind  (area_write),
      .advance (advance),
      .pos     (cur_pos)
   );

   // Input stage.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = render_enable_ff;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_pixel_color;
         s1_pos_ff   <= cur_pos;
      end
   end

   blaw_swizzle #(
      .BUFFER_WIDTH (BUFFER_WIDTH)
   ) u_swizzle (
      .x            (s1_pos_ff.x),
      .y            (s1_pos_ff.y),
      .word_address (s1_addr)
   );

   // Result stage.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_addr_ff  <= s1_addr;
         rsp_pixel_ff <= s1_pixel_ff;
         rsp_last_ff  <= s1_pos_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_word_address = rsp_addr_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_last_of_area = rsp_last_ff;

   // A pixel transferred while rendering is off never enters the pipeline.
   a_drop_disabled: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !render_enable_ff) |=> !s1_valid_ff)
      else $error("dropped pixel entered the input stage");

   // After the closing pixel of the rectangle the counters sit at the start corner.
   a_rewind_on_last: assert property (@(posedge clock) disable iff (reset)
      (advance && cur_pos.last && !area_write)
      |=> (cur_pos.x == area_ff.left && cur_pos.y == area_ff.top))
      else $error("counters did not rewind after the last pixel");

   // An area write puts the counters back at the start corner.
   a_rewind_on_write: assert property (@(posedge clock) disable iff (reset)
      area_write |=> (cur_pos.x == area_ff.left && cur_pos.y == area_ff.top))
      else $error("counters did not rewind after an area write");

   // A held input stage keeps its pixel while the result stage is blocked.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_pixel_ff)))
      else $error("input stage lost its pixel while stalled");

endmodule

// ----- test/pixel_address_checker.sv -----
`timescale 1ns / 1ps
// Checker for the block-linear area pixel writer: follows the register writes and pixel transfers,
// works out each pixel's block-linear word address and compares every result transfer.
// Depends on blaw_pkg.
module pixel_address_checker #(
   parameter int BUFFER_WIDTH = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  blaw_pkg::csr_idx_type csr_index,
   input  blaw_pkg::csr_dat_type csr_write_data,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  blaw_pkg::pixel_type   req_pixel_color,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  blaw_pkg::addr_type    rsp_word_address,
   input  blaw_pkg::pixel_type   rsp_pixel_out,
   input  logic                  rsp_last_of_area,
   output int                    mismatch_count,
   output int                    pixels_in_flight
);
   import blaw_pkg::*;

   typedef struct packed {
      addr_type  word_address;
      pixel_type pixel;
      logic      last;
   } placed_pixel_type;

   area_type         area;
   logic             render_on;
   coord_type        column_now;
   coord_type        row_now;
   placed_pixel_type expected_pixels[$];

   // A GOB is 16x16 words and a block stacks eight GOBs, so 128 rows share one block row.
   function automatic addr_type swizzle_word_address(coord_type x, coord_type y);
      int unsigned xi;
      int unsigned yi;
      int unsigned gob;
      int unsigned adr;
      xi  = 32'(x);
      yi  = 32'(y);
      gob = ((yi & 127) >> 4) + (xi >> 4) * 8 + (yi >> 7) * ((BUFFER_WIDTH / 16) * 8);
      adr = gob * 256 + ((yi >> 3) & 1) * 128 + ((xi >> 3) & 1) * 64
            + ((yi >> 1) & 3) * 16 + ((xi >> 2) & 1) * 8 + (yi & 1) * 4 + (xi & 3);
      return adr[ADDR_W-1:0];
   endfunction

   function automatic void return_to_corner();
      column_now = area.left;
      row_now    = area.top;
   endfunction

   always @(posedge clock) begin : watch
      placed_pixel_type want;
      logic             row_end;
      logic             last;
      if (reset) begin
         area.left      = AREA_LEFT_RST;
         area.right     = AREA_RIGHT_RST;
         area.top       = AREA_TOP_RST;
         area.bottom    = AREA_BOTTOM_RST;
         render_on      = 1'b1;
         mismatch_count = 0;
         return_to_corner();
         expected_pixels.delete();
      end else begin
         // Results are compared before this edge's pixel is predicted, as they are always older.
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none expected: address %h pixel %h last %b",
                        $time, rsp_word_address, rsp_pixel_out, rsp_last_of_area);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_word_address !== want.word_address) begin
                  mismatch_count++;
                  $display("%0t: word_address expected %h, got %h",
                           $time, want.word_address, rsp_word_address);
               end
               if (rsp_pixel_out !== want.pixel) begin
                  mismatch_count++;
                  $display("%0t: pixel_out expected %h, got %h",
                           $time, want.pixel, rsp_pixel_out);
               end
               if (rsp_last_of_area !== want.last) begin
                  mismatch_count++;
                  $display("%0t: last_of_area expected %b, got %b",
                           $time, want.last, rsp_last_of_area);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_AREA_LEFT: begin
                  area.left = csr_write_data;
                  return_to_corner();
               end
               CSR_AREA_RIGHT: begin
                  area.right = csr_write_data;
                  return_to_corner();
               end
               CSR_AREA_TOP: begin
                  area.top = csr_write_data;
                  return_to_corner();
               end
               CSR_AREA_BOTTOM: begin
                  area.bottom = csr_write_data;
                  return_to_corner();
               end
               CSR_RENDER_ENABLE: render_on = csr_write_data[0];
               default: ;
            endcase
         end
         // With rendering off a pixel is dropped and the counters stay where they are.
         if (req_valid && req_ready && render_on) begin
            row_end = column_now >= area.right;
            last    = row_end && (row_now >= area.bottom);
            expected_pixels.push_back({swizzle_word_address(column_now, row_now),
                                       req_pixel_color, last});
            if (last) begin
               return_to_corner();
            end else if (row_end) begin
               column_now = area.left;
               row_now    = row_now + 1'b1;
            end else begin
               column_now = column_now + 1'b1;
            end
         end
      end
      pixels_in_flight = expected_pixels.size();
   end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for block_linear_area_pixel_writer: clock, reset, pixel and register stimulus
// with random stalls on both channels, and the verdict. Depends on blaw_pkg, the block and
// pixel_address_checker.
module tb;
   import blaw_pkg::*;

   localparam int          BUFFER_WIDTH  = 512;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          DRAIN_CYCLES  = 6;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          PIXEL_TARGET  = 1350;
   localparam coord_type   COORD_MIN     = '0;
   localparam coord_type   COORD_MAX     = '1;
   localparam csr_idx_type CSR_SPARE_LO  = CSR_RENDER_ENABLE + 1'b1;
   localparam csr_idx_type CSR_SPARE_HI  = '1;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   csr_idx_type csr_index;
   csr_dat_type csr_write_data;
   logic        req_valid;
   logic        req_ready;
   pixel_type   req_pixel_color;
   logic        rsp_valid;
   logic        rsp_ready;
   addr_type    rsp_word_address;
   pixel_type   rsp_pixel_out;
   logic        rsp_last_of_area;
   int          mismatch_count;
   int          pixels_in_flight;

   int          tx_idle_pct;
   int          rx_idle_pct;
   int          hold_requests;
   logic        render_on;
   int          pixels_placed;
   int unsigned cycle_count;

   block_linear_area_pixel_writer #(.BUFFER_WIDTH(BUFFER_WIDTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_color  (req_pixel_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word_address (rsp_word_address),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_last_of_area (rsp_last_of_area)
   );

   pixel_address_checker #(.BUFFER_WIDTH(BUFFER_WIDTH)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_color  (req_pixel_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word_address (rsp_word_address),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_last_of_area (rsp_last_of_area),
      .mismatch_count   (mismatch_count),
      .pixels_in_flight (pixels_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // The receiver decides at the rising edge and drives at the falling one. A long hold-off
   // is counted here while the sender keeps offering pixels.
   initial begin : receiver
      int   hold_left;
      int   holds_taken;
      logic take;
      hold_left   = 0;
      holds_taken = 0;
      rsp_ready   = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            take = $urandom_range(99) >= rx_idle_pct;
         end
         @(negedge clock);
         rsp_ready <= take;
      end
   end

   task automatic send_pixel(input pixel_type color);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_color <= color;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
      if (render_on)
         pixels_placed++;
   endtask

   task automatic send_pixels(input int count);
      repeat (count) send_pixel($urandom);
   endtask

   // Stop offering, wait for every predicted pixel, then give a dropped pixel time to leave.
   task automatic settle();
      req_valid <= 1'b0;
      while (pixels_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type index, input csr_dat_type data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      if (index == CSR_RENDER_ENABLE)
         render_on = data[0];
   endtask

   task automatic set_area(input coord_type left, right, top, bottom);
      write_reg(CSR_AREA_LEFT, left);
      write_reg(CSR_AREA_RIGHT, right);
      write_reg(CSR_AREA_TOP, top);
      write_reg(CSR_AREA_BOTTOM, bottom);
   endtask

   // Mostly small rectangles, so that row ends and the closing pixel come often.
   task automatic run_phase(input int tx_pct, input int rx_pct, input int placed_goal);
      int          choice;
      int          span_x;
      int          span_y;
      coord_type   left;
      coord_type   top;
      csr_dat_type data;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      while (pixels_placed < placed_goal) begin
         choice = $urandom_range(99);
         if (choice < 70) begin
            left   = coord_type'($urandom_range(511));
            top    = coord_type'($urandom_range(511));
            span_x = $urandom_range(7);
            span_y = $urandom_range(5);
            set_area(left, (left + span_x > 511) ? COORD_MAX : coord_type'(left + span_x),
                     top, (top + span_y > 511) ? COORD_MAX : coord_type'(top + span_y));
            write_reg(CSR_RENDER_ENABLE, csr_dat_type'(1'b1));
         end else if (choice < 85) begin
            set_area(coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), coord_type'($urandom));
            write_reg(CSR_RENDER_ENABLE, csr_dat_type'(1'b1));
         end else if (choice < 92) begin
            set_area($urandom_range(1) ? COORD_MAX : COORD_MIN,
                     $urandom_range(1) ? COORD_MAX : COORD_MIN,
                     $urandom_range(1) ? COORD_MAX : COORD_MIN,
                     $urandom_range(1) ? COORD_MAX : COORD_MIN);
            write_reg(CSR_RENDER_ENABLE, csr_dat_type'(1'b1));
         end else begin
            // The counters carry on from where the last stretch left them.
            data = csr_dat_type'($urandom);
            write_reg(CSR_RENDER_ENABLE, data);
            if ($urandom_range(1))
               write_reg(csr_idx_type'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)),
                         csr_dat_type'($urandom));
         end
         send_pixels($urandom_range(8, 48));
         settle();
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_AREA_LEFT;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_pixel_color  = '0;
      tx_idle_pct      = 37;
      rx_idle_pct      = 78;
      hold_requests    = 0;
      render_on        = 1'b1;
      pixels_placed    = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full field after reset, with the pixel value at its extremes.
      send_pixel('0);
      send_pixel('1);
      send_pixel(32'hAAAA_AAAA);
      send_pixel(32'h5555_5555);
      settle();

      // Bottom-right corner of the field; the fifth pixel starts the rectangle again.
      set_area(9'd510, 9'd511, 9'd510, 9'd511);
      send_pixels(5);
      settle();

      // Render enable writes leave the counters alone, and dropped pixels do not move them.
      write_reg(CSR_RENDER_ENABLE, csr_dat_type'(1'b1));
      send_pixels(1);
      settle();
      write_reg(CSR_RENDER_ENABLE, csr_dat_type'(1'b0));
      send_pixels(2);
      settle();
      write_reg(CSR_RENDER_ENABLE, csr_dat_type'(1'b1));
      send_pixels(1);
      settle();

      // Start beyond end: one pixel per row, then a single row that is one pixel long.
      set_area(9'd300, 9'd12, 9'd200, 9'd202);
      send_pixels(4);
      settle();
      set_area(9'd7, 9'd3, 9'd260, 9'd5);
      send_pixels(2);
      settle();

      // Writes to unused indexes must change nothing.
      for (int i = CSR_SPARE_LO; i <= CSR_SPARE_HI; i++)
         write_reg(csr_idx_type'(i), (i % 2 == 1) ? '1 : '0);
      send_pixels(1);
      settle();

      run_phase(37, 78, PIXEL_TARGET / 3);
      run_phase(78, 37, 2 * PIXEL_TARGET / 3);

      // Receiver holds off while the sender keeps offering, so the input stalls.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_area(9'd40, 9'd47, 9'd100, 9'd103);
      write_reg(CSR_RENDER_ENABLE, csr_dat_type'(1'b1));
      hold_requests++;
      send_pixels(40);
      settle();
      run_phase(0, 0, PIXEL_TARGET);

      settle();
      if (mismatch_count == 0 && pixels_in_flight == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
